// File: design/cli_pkg.sv
`default_nettype none

package cli_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cli_reg_e;

  // Hit counts
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_ONE  = 2'd1;
  localparam logic [1:0] HIT_TWO  = 2'd2;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned R2_W    = 2 * RADIUS_W;    // radius squared
  localparam int unsigned DMAG_W  = 65;              // |det|
  localparam int unsigned DELTA_W = 33;              // |dx|, |dy|
  localparam int unsigned DR2_W   = 68;              // dx^2 + dy^2
  localparam int unsigned RAD_W   = 128;             // discriminant
  localparam int unsigned ROOT_W  = 64;              // its square root
  localparam int unsigned REM_W   = 68;              // root remainder
  localparam int unsigned MAG_W   = 101;             // |numerator|
  localparam int unsigned NUM_W   = MAG_W + 1;       // signed numerator
  localparam int unsigned QUO_W   = 34;              // quotient bits kept
  localparam int unsigned LANES   = 4;               // a_x, a_y, b_x, b_y

  // Line geometry carried alongside the square root
  typedef struct packed {
    logic [1:0]         hit;
    logic               det_neg;
    logic [DMAG_W-1:0]  det_mag;
    logic               dx_neg;
    logic [DELTA_W-1:0] dx_mag;
    logic               dy_neg;
    logic [DELTA_W-1:0] dy_mag;
    logic [DR2_W-1:0]   dr2;
  } cli_geom_t;

  // One divider lane
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } cli_lane_t;

endpackage

`default_nettype wire

// File: design/cli_front.sv
`default_nettype none

module cli_front
  import cli_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [COORD_W-1:0]  p0_x_i,
  input  logic [COORD_W-1:0]  p0_y_i,
  input  logic [COORD_W-1:0]  p1_x_i,
  input  logic [COORD_W-1:0]  p1_y_i,
  input  logic [COORD_W-1:0]  center_x_i,
  input  logic [COORD_W-1:0]  center_y_i,
  input  logic [R2_W-1:0]     r2_i,
  output logic                valid_o,
  output logic [RAD_W-1:0]    disc_o,
  output cli_geom_t           geom_o
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] vld_q;

  // stage 1: into the circle frame
  logic signed [32:0] x1_q, y1_q, x2_q, y2_q;
  // stage 2: deltas and cross products
  logic signed [33:0] dx_q, dy_q;
  logic signed [65:0] pa_q, pb_q;
  // stage 3: squares, determinant, delta magnitudes
  logic signed [67:0] dxsq_q, dysq_q;
  logic signed [65:0] det_q;
  logic               dxn3_q, dyn3_q;
  logic [DELTA_W-1:0] dxm3_q, dym3_q;
  // stage 4..7
  cli_geom_t          g4_q, g5_q, g6_q, g7_q;
  logic [63:0]        pll_q, plh_q, phh_q;
  logic [64:0]        q00_q, q01_q, q10_q, q11_q;
  logic [RAD_W-1:0]   d2_q, rr_q, disc_q;

  cli_geom_t          g4_d, g7_d;
  logic               rr_lt, rr_eq;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  // stage 4 geometry
  always_comb begin
    g4_d         = '0;
    g4_d.hit     = HIT_NONE;
    g4_d.dr2     = DR2_W'(dxsq_q + dysq_q);
    g4_d.det_neg = det_q[65];
    g4_d.det_mag = det_q[65] ? DMAG_W'(-det_q) : DMAG_W'(det_q);
    g4_d.dx_neg  = dxn3_q;
    g4_d.dx_mag  = dxm3_q;
    g4_d.dy_neg  = dyn3_q;
    g4_d.dy_mag  = dym3_q;
  end

  // stage 7 classification
  always_comb begin
    rr_lt = rr_q < d2_q;
    rr_eq = rr_q == d2_q;
    g7_d  = g6_q;
    if (g6_q.dr2 == '0 || g6_q.det_mag[DMAG_W-1] || rr_lt) begin
      g7_d.hit = HIT_NONE;
    end else if (rr_eq) begin
      g7_d.hit = HIT_ONE;
    end else begin
      g7_d.hit = HIT_TWO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q <= $signed({p0_x_i[31], p0_x_i}) - $signed({center_x_i[31], center_x_i});
      y1_q <= $signed({p0_y_i[31], p0_y_i}) - $signed({center_y_i[31], center_y_i});
      x2_q <= $signed({p1_x_i[31], p1_x_i}) - $signed({center_x_i[31], center_x_i});
      y2_q <= $signed({p1_y_i[31], p1_y_i}) - $signed({center_y_i[31], center_y_i});

      dx_q <= $signed({x2_q[32], x2_q}) - $signed({x1_q[32], x1_q});
      dy_q <= $signed({y2_q[32], y2_q}) - $signed({y1_q[32], y1_q});
      pa_q <= 66'(x1_q) * 66'(y2_q);
      pb_q <= 66'(x2_q) * 66'(y1_q);

      dxsq_q <= 68'(dx_q) * 68'(dx_q);
      dysq_q <= 68'(dy_q) * 68'(dy_q);
      det_q  <= pa_q - pb_q;
      dxn3_q <= dx_q[33];
      dyn3_q <= dy_q[33];
      dxm3_q <= dx_q[33] ? DELTA_W'(-dx_q) : DELTA_W'(dx_q);
      dym3_q <= dy_q[33] ? DELTA_W'(-dy_q) : DELTA_W'(dy_q);

      g4_q <= g4_d;

      // det^2 and dr2*r^2 as 32-bit-ish partial products
      pll_q <= 64'(g4_q.det_mag[31:0]) * 64'(g4_q.det_mag[31:0]);
      plh_q <= 64'(g4_q.det_mag[31:0]) * 64'(g4_q.det_mag[63:32]);
      phh_q <= 64'(g4_q.det_mag[63:32]) * 64'(g4_q.det_mag[63:32]);
      q00_q <= 65'(g4_q.dr2[33:0]) * 65'(r2_i[30:0]);
      q01_q <= 65'(g4_q.dr2[33:0]) * 65'(r2_i[61:31]);
      q10_q <= 65'(g4_q.dr2[67:34]) * 65'(r2_i[30:0]);
      q11_q <= 65'(g4_q.dr2[67:34]) * 65'(r2_i[61:31]);
      g5_q  <= g4_q;

      // sum partials; r^2*dr2 wraps at 128 bits
      d2_q <= RAD_W'(pll_q) + (RAD_W'(plh_q) << 33) + (RAD_W'(phh_q) << 64);
      rr_q <= RAD_W'(q00_q) + (RAD_W'(q01_q) << 31) + (RAD_W'(q10_q) << 34)
            + (RAD_W'(q11_q) << 65);
      g6_q <= g5_q;

      disc_q <= rr_q - d2_q;
      g7_q   <= g7_d;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign disc_o  = disc_q;
  assign geom_o  = g7_q;

endmodule

`default_nettype wire

// File: design/cli_sqrt.sv
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module cli_sqrt
  import cli_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  cli_geom_t         geom_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output cli_geom_t         geom_o
);

  logic [REM_W-1:0]  rem_w  [ROOT_W+1];
  logic [ROOT_W-1:0] root_w [ROOT_W+1];
  logic [RAD_W-1:0]  rad_w  [ROOT_W+1];
  cli_geom_t         geom_w [ROOT_W+1];
  logic [ROOT_W:0]   vld_w;

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = rad_i;
  assign geom_w[0] = geom_i;
  assign vld_w[0]  = valid_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_sh, trial, rem_n;
    logic              ge;
    logic [REM_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;
    logic [RAD_W-1:0]  rad_q;
    cli_geom_t         geom_q;
    logic              vld_q;

    // bring down two radicand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_w[k][REM_W-3:0], rad_w[k][RAD_W-1 -: 2]};
      trial  = REM_W'({root_w[k], 2'b01});
      ge     = rem_sh >= trial;
      rem_n  = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_n;
        root_q <= {root_w[k][ROOT_W-2:0], ge};
        rad_q  <= rad_w[k] << 2;
        geom_q <= geom_w[k];
      end
    end

    assign rem_w[k+1]  = rem_q;
    assign root_w[k+1] = root_q;
    assign rad_w[k+1]  = rad_q;
    assign geom_w[k+1] = geom_q;
    assign vld_w[k+1]  = vld_q;
  end

  assign valid_o = vld_w[ROOT_W];
  assign root_o  = root_w[ROOT_W];
  assign geom_o  = geom_w[ROOT_W];

endmodule

`default_nettype wire

// File: design/cli_div.sv
`default_nettype none

// Four-lane pipelined divider |num| / dr2, one quotient bit per stage.
// Quotients of 2^QUO_W or more only raise ovf.
module cli_div
  import cli_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][MAG_W-1:0] mag_i,
  input  logic [LANES-1:0]            neg_i,
  input  logic [DR2_W-1:0]            dr2_i,
  input  logic [1:0]                  hit_i,
  output logic                        valid_o,
  output cli_lane_t [LANES-1:0]       lane_o,
  output logic [1:0]                  hit_o
);

  cli_lane_t [LANES-1:0] lane_w [QUO_W+1];
  logic [DR2_W-1:0]      dr2_w  [QUO_W+1];
  logic [1:0]            hit_w  [QUO_W+1];
  logic [QUO_W:0]        vld_w;

  // entry stage: overflow check
  cli_lane_t [LANES-1:0] lane0_d, lane0_q;
  logic [DR2_W-1:0]      dr20_q;
  logic [1:0]            hit0_q;
  logic                  vld0_q;
  logic [NUM_W-1:0]      dlim;

  always_comb begin
    dlim = NUM_W'(dr2_i) << QUO_W;
    for (int l = 0; l < LANES; l++) begin
      lane0_d[l].neg = neg_i[l];
      lane0_d[l].ovf = {1'b0, mag_i[l]} >= dlim;
      lane0_d[l].rem = lane0_d[l].ovf ? '0 : mag_i[l];
      lane0_d[l].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane0_q <= lane0_d;
      dr20_q  <= dr2_i;
      hit0_q  <= hit_i;
    end
  end

  assign lane_w[0] = lane0_q;
  assign dr2_w[0]  = dr20_q;
  assign hit_w[0]  = hit0_q;
  assign vld_w[0]  = vld0_q;

  for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
    cli_lane_t [LANES-1:0] lane_d, lane_q;
    logic [NUM_W-1:0]      dsh;
    logic [DR2_W-1:0]      dr2_q;
    logic [1:0]            hit_q;
    logic                  vld_q;

    // restoring step against dr2 shifted to this bit
    always_comb begin
      dsh    = NUM_W'(dr2_w[j-1]) << (QUO_W - j);
      lane_d = lane_w[j-1];
      for (int l = 0; l < LANES; l++) begin
        if ({1'b0, lane_w[j-1][l].rem} >= dsh) begin
          lane_d[l].rem = lane_w[j-1][l].rem - dsh[MAG_W-1:0];
          lane_d[l].quo = {lane_w[j-1][l].quo[QUO_W-2:0], 1'b1};
        end else begin
          lane_d[l].quo = {lane_w[j-1][l].quo[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q <= lane_d;
        dr2_q  <= dr2_w[j-1];
        hit_q  <= hit_w[j-1];
      end
    end

    assign lane_w[j] = lane_q;
    assign dr2_w[j]  = dr2_q;
    assign hit_w[j]  = hit_q;
    assign vld_w[j]  = vld_q;
  end

  assign valid_o = vld_w[QUO_W];
  assign lane_o  = lane_w[QUO_W];
  assign hit_o   = hit_w[QUO_W];

endmodule

`default_nettype wire

// File: design/circle_line_intersect_core.sv
// Channel | Signals                                     | Direction
// --------+---------------------------------------------+----------
// in      | in_valid_i, in_stall_o, p0_x/p0_y/p1_x/p1_y | into core
// out     | out_valid_o, out_stall_i, hit_count, a, b   | out of core
// cfg     | cfg_valid_i, cfg_ready_o, cfg_index/data    | into core
//
// One item enters per cycle while the pipeline is not stalled. An item passes
// 112 register stages: 7 front stages, 64 square root stages (one root bit
// each), 5 numerator stages, 35 divider stages (one quotient bit each) and
// 1 output.
// Reset clears the circle registers and all valid bits; no clearing pass.
// A stalled output freezes the whole pipeline, so in_stall_o follows
// out_stall_i while a result is held.
`default_nettype none

module circle_line_intersect_core
  import cli_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COORD_W-1:0] p0_x_i,
  input  logic [COORD_W-1:0] p0_y_i,
  input  logic [COORD_W-1:0] p1_x_i,
  input  logic [COORD_W-1:0] p1_y_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         hit_count_o,
  output logic [COORD_W-1:0] a_x_o,
  output logic [COORD_W-1:0] a_y_o,
  output logic [COORD_W-1:0] b_x_o,
  output logic [COORD_W-1:0] b_y_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [COORD_W-1:0] cfg_data_i
);

  localparam int unsigned SUM_W = QUO_W + 3;

  logic en;

  // ---------------- configuration ----------------
  logic [COORD_W-1:0]  center_x_q, center_y_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [R2_W-1:0]     r2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
      r2_q       <= '0;
    end else begin
      r2_q <= R2_W'(radius_q) * R2_W'(radius_q);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_CENTER_X: center_x_q <= cfg_data_i;
          REG_CENTER_Y: center_y_q <= cfg_data_i;
          REG_RADIUS:   radius_q   <= cfg_data_i[RADIUS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- front and square root ----------------
  logic             fr_valid;
  logic [RAD_W-1:0] fr_disc;
  cli_geom_t        fr_geom;

  cli_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .p0_x_i     (p0_x_i),
    .p0_y_i     (p0_y_i),
    .p1_x_i     (p1_x_i),
    .p1_y_i     (p1_y_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .r2_i       (r2_q),
    .valid_o    (fr_valid),
    .disc_o     (fr_disc),
    .geom_o     (fr_geom)
  );

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  cli_geom_t         sq_geom;

  cli_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_disc),
    .geom_i  (fr_geom),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .geom_o  (sq_geom)
  );

  // ---------------- numerators ----------------
  logic [4:0]       nv_q;
  cli_geom_t        g1_q, g2_q, g3_q, g4_q, g5_q;
  logic [65:0]      pdy_l_q, pdx_l_q;
  logic [64:0]      pdy_h_q, pdx_h_q, psx_l_q, psx_h_q, psy_l_q, psy_h_q;
  logic [MAG_W-1:0] mt1_q, mt2_q, mu_q, mv_q;
  logic             n1_q, n2_q, nu_q;
  logic signed [NUM_W-1:0] st1_q, st2_q, su_q, sv_q;
  logic signed [NUM_W-1:0] nax_q, nay_q, nbx_q, nby_q;
  logic [LANES-1:0][MAG_W-1:0] mag_q;
  logic [LANES-1:0]            neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= '0;
    end else if (en) begin
      nv_q <= {nv_q[3:0], sq_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // partial products of det*dy, det*dx, s*dx, s*dy
      pdy_l_q <= 66'(sq_geom.det_mag[32:0]) * 66'(sq_geom.dy_mag);
      pdy_h_q <= 65'(sq_geom.det_mag[64:33]) * 65'(sq_geom.dy_mag);
      pdx_l_q <= 66'(sq_geom.det_mag[32:0]) * 66'(sq_geom.dx_mag);
      pdx_h_q <= 65'(sq_geom.det_mag[64:33]) * 65'(sq_geom.dx_mag);
      psx_l_q <= 65'(sq_root[31:0]) * 65'(sq_geom.dx_mag);
      psx_h_q <= 65'(sq_root[63:32]) * 65'(sq_geom.dx_mag);
      psy_l_q <= 65'(sq_root[31:0]) * 65'(sq_geom.dy_mag);
      psy_h_q <= 65'(sq_root[63:32]) * 65'(sq_geom.dy_mag);
      g1_q    <= sq_geom;

      // magnitudes and signs
      mt1_q <= MAG_W'(pdy_l_q) + (MAG_W'(pdy_h_q) << 33);
      mt2_q <= MAG_W'(pdx_l_q) + (MAG_W'(pdx_h_q) << 33);
      mu_q  <= MAG_W'(psx_l_q) + (MAG_W'(psx_h_q) << 32);
      mv_q  <= MAG_W'(psy_l_q) + (MAG_W'(psy_h_q) << 32);
      n1_q  <= g1_q.det_neg ^ g1_q.dy_neg;
      n2_q  <= ~(g1_q.det_neg ^ g1_q.dx_neg);
      nu_q  <= g1_q.dx_neg ^ g1_q.dy_neg;
      g2_q  <= g1_q;

      // signed terms
      st1_q <= n1_q ? -$signed({1'b0, mt1_q}) : $signed({1'b0, mt1_q});
      st2_q <= n2_q ? -$signed({1'b0, mt2_q}) : $signed({1'b0, mt2_q});
      su_q  <= nu_q ? -$signed({1'b0, mu_q}) : $signed({1'b0, mu_q});
      sv_q  <= $signed({1'b0, mv_q});
      g3_q  <= g2_q;

      // numerators of both points
      nax_q <= st1_q + su_q;
      nay_q <= st2_q + sv_q;
      nbx_q <= st1_q - su_q;
      nby_q <= st2_q - sv_q;
      g4_q  <= g3_q;

      // sign and magnitude for the divider
      mag_q[0] <= nax_q[NUM_W-1] ? MAG_W'(-nax_q) : MAG_W'(nax_q);
      mag_q[1] <= nay_q[NUM_W-1] ? MAG_W'(-nay_q) : MAG_W'(nay_q);
      mag_q[2] <= nbx_q[NUM_W-1] ? MAG_W'(-nbx_q) : MAG_W'(nbx_q);
      mag_q[3] <= nby_q[NUM_W-1] ? MAG_W'(-nby_q) : MAG_W'(nby_q);
      neg_q    <= {nby_q[NUM_W-1], nbx_q[NUM_W-1], nay_q[NUM_W-1], nax_q[NUM_W-1]};
      g5_q     <= g4_q;
    end
  end

  // ---------------- division ----------------
  logic                  dv_valid;
  cli_lane_t [LANES-1:0] dv_lane;
  logic [1:0]            dv_hit;

  cli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nv_q[4]),
    .mag_i   (mag_q),
    .neg_i   (neg_q),
    .dr2_i   (g5_q.dr2),
    .hit_i   (g5_q.hit),
    .valid_o (dv_valid),
    .lane_o  (dv_lane),
    .hit_o   (dv_hit)
  );

  // ---------------- output register ----------------
  function automatic logic [COORD_W-1:0] fin_coord(input cli_lane_t ln,
                                                   input logic [COORD_W-1:0] c);
    logic [QUO_W:0]          m;
    logic signed [SUM_W-1:0] sv, sum;
    logic [COORD_W-1:0]      res;
    m   = ln.ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, ln.quo};
    sv  = ln.neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    sum = sv + $signed({{(SUM_W-COORD_W){c[COORD_W-1]}}, c});
    if (!sum[SUM_W-1] && (sum[SUM_W-2:COORD_W-1] != '0)) begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (sum[SUM_W-1] && (sum[SUM_W-2:COORD_W-1] != '1)) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = sum[COORD_W-1:0];
    end
    return res;
  endfunction

  logic out_valid_q;
  logic [1:0] hit_q;
  logic [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic nohit;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign nohit      = dv_hit == HIT_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= dv_hit;
      ax_q  <= nohit ? '0 : fin_coord(dv_lane[0], center_x_q);
      ay_q  <= nohit ? '0 : fin_coord(dv_lane[1], center_y_q);
      bx_q  <= nohit ? '0 : fin_coord(dv_lane[2], center_x_q);
      by_q  <= nohit ? '0 : fin_coord(dv_lane[3], center_y_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_count_o = hit_q;
  assign a_x_o       = ax_q;
  assign a_y_o       = ay_q;
  assign b_x_o       = bx_q;
  assign b_y_o       = by_q;

  // ---------------- assertions ----------------
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hit_count_o != 2'd3)
    else $error("hit count out of range");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_count_o == HIT_NONE |->
      a_x_o == '0 && a_y_o == '0 && b_x_o == '0 && b_y_o == '0)
    else $error("miss with nonzero points");

  a_tangent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_count_o == HIT_ONE |-> b_x_o == a_x_o && b_y_o == a_y_o)
    else $error("tangent with two distinct points");

endmodule

`default_nettype wire

// File: tb/sv/tb_circle_line_intersect_core.sv
`default_nettype none

module tb_circle_line_intersect_core
  import cli_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_DEPTH  = 112;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [COORD_W-1:0] p0x;
    logic [COORD_W-1:0] p0y;
    logic [COORD_W-1:0] p1x;
    logic [COORD_W-1:0] p1y;
  } line_item_t;

  typedef struct {
    logic [1:0]         hit;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } crossing_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [COORD_W-1:0] p0_x_i, p0_y_i, p1_x_i, p1_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         hit_count_o;
  logic [COORD_W-1:0] a_x_o, a_y_o, b_x_o, b_y_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [COORD_W-1:0] cfg_data_i;

  circle_line_intersect_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .p0_x_i      (p0_x_i),
    .p0_y_i      (p0_y_i),
    .p1_x_i      (p1_x_i),
    .p1_y_i      (p1_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_count_o (hit_count_o),
    .a_x_o       (a_x_o),
    .a_y_o       (a_y_o),
    .b_x_o       (b_x_o),
    .b_y_o       (b_y_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // circle held by the predictor
  logic signed [63:0] circ_cx;
  logic signed [63:0] circ_cy;
  logic [30:0]        circ_r;

  line_item_t  line_q[$];
  crossing_t   crossing_q[$];
  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned hold_cnt;
  bit          hold_req;
  bit          in_fire;
  int unsigned err_cnt;
  int unsigned quiet_cnt;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // saturate a wide value to the signed coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [63:0] val);
    if (val > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (val < -64'sh8000_0000) return 32'h8000_0000;
    return val[31:0];
  endfunction

  // one intersection coordinate: truncating divide, clamp, add center
  function automatic logic [COORD_W-1:0] cross_coord(input logic signed [129:0] num,
                                                     input logic [129:0] dr2,
                                                     input logic signed [63:0] cen);
    logic [129:0]       mag;
    logic [129:0]       quo;
    logic signed [63:0] val;
    mag = (num < 0) ? -num : num;
    quo = mag / dr2;
    if (quo > (130'd1 << 40)) quo = 130'd1 << 40;
    val = (num < 0) ? -$signed({1'b0, quo[62:0]}) : $signed({1'b0, quo[62:0]});
    return sat_coord(val + cen);
  endfunction

  // expected crossing of the configured circle with one line
  function automatic crossing_t circle_crossing(input line_item_t it);
    crossing_t          res;
    logic signed [63:0] x1, y1, x2, y2, dx, dy, sdx, ady;
    logic signed [129:0] det, t1, t2, u, v, sroot;
    logic [129:0]       dr2, detm, d2, rr, disc;
    logic [63:0]        rsq, root, cand;
    res = '{HIT_NONE, '0, '0, '0, '0};
    x1 = 64'($signed(it.p0x)) - circ_cx;
    y1 = 64'($signed(it.p0y)) - circ_cy;
    x2 = 64'($signed(it.p1x)) - circ_cx;
    y2 = 64'($signed(it.p1y)) - circ_cy;
    dx = x2 - x1;
    dy = y2 - y1;
    dr2 = dx * dx + dy * dy;
    det = x1 * y2 - x2 * y1;
    if (dr2 == 0) return res;
    detm = (det < 0) ? -det : det;
    if (detm >= (130'd1 << 64)) return res;
    d2 = detm * detm;
    rsq = {33'd0, circ_r} * {33'd0, circ_r};
    rr = dr2 * {66'd0, rsq};
    rr = {2'b00, rr[127:0]};
    if (rr < d2) return res;
    disc = rr - d2;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if ({66'd0, cand} * {66'd0, cand} <= disc) root = cand;
    end
    sroot = {66'd0, root};
    sdx = (dy < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    t1 = det * dy;
    t2 = -(det * dx);
    u = sdx * sroot;
    v = ady * sroot;
    res.hit = (rr == d2) ? HIT_ONE : HIT_TWO;
    res.ax = cross_coord(t1 + u, dr2, circ_cx);
    res.ay = cross_coord(t2 + v, dr2, circ_cy);
    res.bx = cross_coord(t1 - u, dr2, circ_cx);
    res.by = cross_coord(t2 - v, dr2, circ_cy);
    return res;
  endfunction

  // random 64-bit value in [-span, span]
  function automatic logic signed [63:0] rand_offset(input logic signed [63:0] span);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return $signed(raw % (2 * span + 1)) - span;
  endfunction

  // random line: mostly near the circle, some tangents, repeats and noise
  function automatic line_item_t rand_line();
    line_item_t         it;
    logic signed [63:0] scale, ofs;
    int unsigned        kind;
    scale = (circ_r > 256) ? 64'(circ_r) : 64'sd256;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      it = '{$urandom, $urandom, $urandom, $urandom};
    end else if (kind == 2) begin
      // horizontal or vertical tangent
      ofs = ($urandom_range(0, 1) != 0) ? 64'(circ_r) : -64'(circ_r);
      if ($urandom_range(0, 1) != 0) begin
        it.p0x = sat_coord(circ_cx + rand_offset(2 * scale));
        it.p1x = sat_coord(circ_cx + rand_offset(2 * scale));
        it.p0y = sat_coord(circ_cy + ofs);
        it.p1y = it.p0y;
      end else begin
        it.p0y = sat_coord(circ_cy + rand_offset(2 * scale));
        it.p1y = sat_coord(circ_cy + rand_offset(2 * scale));
        it.p0x = sat_coord(circ_cx + ofs);
        it.p1x = it.p0x;
      end
    end else begin
      it.p0x = sat_coord(circ_cx + rand_offset(2 * scale));
      it.p0y = sat_coord(circ_cy + rand_offset(2 * scale));
      it.p1x = sat_coord(circ_cx + rand_offset(2 * scale));
      it.p1y = sat_coord(circ_cy + rand_offset(2 * scale));
      if (kind == 3) begin
        it.p1x = it.p0x;
        it.p1y = it.p0y;
      end
    end
    return it;
  endfunction

  // register write while the core is idle
  task automatic write_reg(input cli_reg_e idx, input logic [COORD_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CENTER_X: circ_cx = 64'($signed(data));
      REG_CENTER_Y: circ_cy = 64'($signed(data));
      default:      circ_r  = data[30:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] r);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, r);
  endtask

  // let the pipeline run dry before touching the circle
  task automatic drain();
    wait (line_q.size() == 0 && !in_valid_i && crossing_q.size() == 0);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
  endtask

  // sender: hold the item until taken, then maybe idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (line_q.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
        line_item_t it;
        it = line_q.pop_front();
        in_valid_i <= 1'b1;
        p0_x_i <= it.p0x;
        p0_y_i <= it.p0y;
        p1_x_i <= it.p1x;
        p1_y_i <= it.p1y;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus the long hold
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle);
    end
  end

  // predict on accept, check on result
  always @(posedge clk_i) begin
    crossing_t want;
    line_item_t it;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      it = '{p0_x_i, p0_y_i, p1_x_i, p1_y_i};
      crossing_q.push_back(circle_crossing(it));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (crossing_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = crossing_q.pop_front();
        if (hit_count_o !== want.hit || a_x_o !== want.ax || a_y_o !== want.ay ||
            b_x_o !== want.bx || b_y_o !== want.by) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch at %0t: exp hit %0d a %h %h b %h %h, got hit %0d a %h %h b %h %h",
                     $realtime, want.hit, want.ax, want.ay, want.bx, want.by,
                     hit_count_o, a_x_o, a_y_o, b_x_o, b_y_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o || out_valid_o && !out_stall_i ||
        cfg_valid_i && cfg_ready_o || !rst_ni) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    p0_x_i      = '0;
    p0_y_i      = '0;
    p1_x_i      = '0;
    p1_y_i      = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_CENTER_X;
    cfg_data_i  = '0;
    circ_cx     = '0;
    circ_cy     = '0;
    circ_r      = '0;
    tx_idle     = 6;
    rx_idle     = 59;
    hold_cnt    = 0;
    hold_req    = 1'b0;
    in_fire     = 1'b0;
    err_cnt     = 0;
    quiet_cnt   = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed lines against a circle of radius 10 * 2^16 at the origin
    set_circle(32'h0, 32'h0, 32'h000A_0000);
    line_q.push_back('{32'h0014_0000, 32'h0014_0000, 32'h001E_0000, 32'h0014_0000}); // miss
    line_q.push_back('{32'hFFFB_0000, 32'h000A_0000, 32'h0005_0000, 32'h000A_0000}); // tangent
    line_q.push_back('{32'h000A_0000, 32'hFFFD_0000, 32'h000A_0000, 32'h0003_0000}); // tangent
    line_q.push_back('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000}); // same pt
    line_q.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
    line_q.push_back('{32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0});                 // center
    line_q.push_back('{32'h0, 32'h0005_0000, 32'h0, 32'hFFFB_0000});                 // dy < 0
    line_q.push_back('{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'hFFF9_0000});
    line_q.push_back('{32'hFFFB_0000, 32'h0009_FFFF, 32'h0005_0000, 32'h0009_FFFF}); // tiny disc
    line_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    line_q.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    line_q.push_back('{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    line_q.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    line_q.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    line_q.push_back('{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001});
    drain();

    // extreme circle far off in one corner; directed extremes again
    set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    line_q.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    line_q.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
    line_q.push_back('{32'h0, 32'h0, 32'h0001_0000, 32'h0});
    tx_idle = 6;
    rx_idle = 59;
    repeat (320) line_q.push_back(rand_line());
    drain();

    // zero radius in the other corner
    set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    repeat (320) line_q.push_back(rand_line());
    drain();

    // random circles, other idling mix
    tx_idle = 59;
    rx_idle = 6;
    set_circle($urandom, $urandom, $urandom_range(1 << 12, 1 << 26));
    repeat (320) line_q.push_back(rand_line());
    drain();

    set_circle(32'($signed($urandom_range(0, 1 << 25)) - (1 << 24)),
               32'($signed($urandom_range(0, 1 << 25)) - (1 << 24)),
               $urandom_range(1 << 16, 1 << 22));
    repeat (320) line_q.push_back(rand_line());
    drain();

    // no idling; the receiver holds off long enough to back up the input
    tx_idle = 0;
    rx_idle = 0;
    set_circle(32'h0, 32'h0, 32'h0003_0000);
    repeat (320) line_q.push_back(rand_line());
    hold_req = 1'b1;
    wait (line_q.size() == 0 && !in_valid_i && crossing_q.size() == 0);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);

    if (crossing_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
design/cli_pkg.sv
design/cli_front.sv
design/cli_sqrt.sv
design/cli_div.sv
design/circle_line_intersect_core.sv
tb/sv/tb_circle_line_intersect_core.sv
